[src/p2c_pkg.sv]
// Shared constants and types for the polar to Cartesian scan converter.
package p2c_pkg;

  // Angles in Q.16 radians
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int TWO_PI_Q16  = 411775;

  // Output saturation bounds, metres Q.16
  localparam int OUT_MAX_Q16 = 268435455;
  localparam int OUT_MIN_Q16 = -268435456;

  // Datapath widths
  localparam int XW  = 32;  // CORDIC x and y, Q.30
  localparam int ZW  = 28;  // CORDIC residual angle, Q.24
  localparam int CW  = 26;  // sine and cosine after the drop to Q.24
  localparam int OW  = 29;  // pos_x and pos_y
  localparam int LW  = 16;  // level

  // Configuration register widths
  localparam int ASW = 20;
  localparam int APW = 17;
  localparam int RSW = 28;
  localparam int RPW = 21;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic signed [ASW-1:0] ANGLE_START_RST = -20'sd205783;
  localparam logic [APW-1:0]        ANGLE_STEP_RST  = 17'd1029;
  localparam logic [RSW-1:0]        RANGE_START_RST = 28'd0;
  localparam logic [RPW-1:0]        RANGE_STEP_RST  = 21'd1914;

  // CORDIC start value, 1/K in Q.30
  localparam logic signed [XW-1:0] GAIN_Q30 = 32'sd652032874;

  // atan(2^-i) in Q.24
  localparam logic [23:0] ATAN_Q24 [24] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
    24'd1047214,  24'd524117,  24'd262123,  24'd131069,
    24'd65536,    24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,
    24'd256,      24'd128,     24'd64,      24'd32,
    24'd16,       24'd8,       24'd4,       24'd2
  };

  typedef enum logic [1:0] {
    REG_ANGLE_START = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_RANGE_START = 2'd2,
    REG_RANGE_STEP  = 2'd3
  } reg_idx_t;

endpackage

[src/p2c_wrap_cell.sv]
// One conditional-subtract cell of the angle wrap chain (subtracts 2*pi << SHIFT).
module p2c_wrap_cell import p2c_pkg::*; #(
  parameter int AW    = 27,
  parameter int SHIFT = 0,
  parameter int SW    = 52
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  output logic          in_rdy,
  input  logic [AW-1:0] in_u,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  input  logic          out_rdy,
  output logic [AW-1:0] out_u,
  output logic [SW-1:0] out_side
);

  localparam logic [AW-1:0] SUB = AW'(TWO_PI_Q16) << SHIFT;

  logic          vld_r;
  logic [AW-1:0] u_r;
  logic [AW-1:0] u_nxt;
  logic [SW-1:0] side_r;

  assign in_rdy = !vld_r || out_rdy;

  always_comb begin
    if (in_u >= SUB) begin
      u_nxt = in_u - SUB;
    end else begin
      u_nxt = in_u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      u_r    <= u_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_u    = u_r;
  assign out_side = side_r;

endmodule

[src/p2c_cordic_cell.sv]
// One rotation-mode CORDIC micro-rotation cell.
module p2c_cordic_cell import p2c_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW  = 52
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  output logic                 in_rdy,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic [SW-1:0]        in_side,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output logic [SW-1:0]        out_side
);

  localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-24){1'b0}}, ATAN_Q24[IDX]});

  logic                 vld_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [SW-1:0]        side_r;
  logic signed [XW-1:0] dx, dy;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;

  assign in_rdy = !vld_r || out_rdy;

  // zero residual rotates anticlockwise
  always_comb begin
    dx = in_y >>> IDX;
    dy = in_x >>> IDX;
    if (!in_z[ZW-1]) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ATAN;
    end else begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_z    = z_r;
  assign out_side = side_r;

endmodule

[src/polar_to_cartesian_scan_convert.sv]
// Top level: polar radar pixel to Cartesian point, fully pipelined cell chain.
//
//  channel   handshake                      payload
//  in_       in_valid / in_stall            in_range_bin, in_azimuth_bin, in_echo
//  out_      out_valid / out_stall          out_pos_x, out_pos_y, out_level
//  cfg_      cfg_psel/penable/pwrite/pready cfg_paddr, cfg_pwdata, cfg_prdata
//
// One item per cycle sustained while out_stall is low. Items pass the entry register,
// the QB = AW - 18 cells of the angle wrap chain, the fold register, the CORDIC cells
// and the sign, product, sum and output registers. Each stage advances when empty or
// when its successor advances, so bubbles close up behind a stalled output. rst_n is
// synchronous; it clears the valid bits and loads the register defaults.
module polar_to_cartesian_scan_convert import p2c_pkg::*; #(
  parameter int MAX_RANGE_BINS   = 4096,
  parameter int MAX_AZIMUTH_BINS = 512,
  parameter int CORDIC_STAGES    = 16,
  localparam int RBW = (MAX_RANGE_BINS > 1) ? $clog2(MAX_RANGE_BINS) : 1,
  localparam int AZW = (MAX_AZIMUTH_BINS > 1) ? $clog2(MAX_AZIMUTH_BINS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [PADDR_W-1:0]   cfg_paddr,
  input  logic [PDATA_W-1:0]   cfg_pwdata,
  output logic [PDATA_W-1:0]   cfg_prdata,
  output logic                 cfg_pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [RBW-1:0]       in_range_bin,
  input  logic [AZW-1:0]       in_azimuth_bin,
  input  logic [7:0]           in_echo,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [OW-1:0] out_pos_x,
  output logic signed [OW-1:0] out_pos_y,
  output logic [LW-1:0]        out_level
);

  // angle accumulator, offset to stay non-negative
  localparam int AW  = (AZW + 18 > 22) ? AZW + 18 : 22;
  localparam int QB  = AW - 18;
  // distance in Q.17
  localparam int DW  = ((RBW + 22 > 29) ? RBW + 22 : 29) + 1;
  localparam int HW  = DW - 17;
  localparam int SW  = DW + LW + 1;
  localparam int LPW = 18 + CW;
  localparam int HPW = HW + 1 + CW;
  localparam int PW  = DW + CW + 1;
  localparam int QW  = PW - 25;
  localparam int NS  = CORDIC_STAGES;

  localparam logic [AW-1:0]          ENTRY_OFS = AW'(PI_Q16 + 2 * TWO_PI_Q16);
  localparam logic signed [19:0]     PI_A      = 20'(PI_Q16);
  localparam logic signed [19:0]     HALF_A    = 20'(HALF_PI_Q16);
  localparam logic signed [19:0]     NHALF_A   = 20'(-HALF_PI_Q16);
  localparam logic signed [ZW-1:0]   ZMAX      = ZW'(HALF_PI_Q16 * 256);
  localparam logic signed [ZW-1:0]   ZMIN      = ZW'(-HALF_PI_Q16 * 256);
  localparam logic signed [PW-1:0]   RND       = PW'(1 << 24);
  localparam logic signed [QW:0]     OMAX      = (QW + 1)'(OUT_MAX_Q16);
  localparam logic signed [QW:0]     OMIN      = (QW + 1)'(OUT_MIN_Q16);

  // ---------------------------------------------------------------- config
  logic signed [ASW-1:0] angle_start_r;
  logic [APW-1:0]        angle_step_r;
  logic [RSW-1:0]        range_start_r;
  logic [RPW-1:0]        range_step_r;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= ANGLE_START_RST;
      angle_step_r  <= ANGLE_STEP_RST;
      range_start_r <= RANGE_START_RST;
      range_step_r  <= RANGE_STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ANGLE_START: angle_start_r <= cfg_pwdata[ASW-1:0];
        REG_ANGLE_STEP:  angle_step_r  <= cfg_pwdata[APW-1:0];
        REG_RANGE_START: range_start_r <= cfg_pwdata[RSW-1:0];
        REG_RANGE_STEP:  range_step_r  <= cfg_pwdata[RPW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ANGLE_START: cfg_prdata = {{(PDATA_W-ASW){1'b0}}, angle_start_r};
      REG_ANGLE_STEP:  cfg_prdata = {{(PDATA_W-APW){1'b0}}, angle_step_r};
      REG_RANGE_START: cfg_prdata = {{(PDATA_W-RSW){1'b0}}, range_start_r};
      REG_RANGE_STEP:  cfg_prdata = {{(PDATA_W-RPW){1'b0}}, range_step_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- entry
  logic                 vE_r;
  logic [AW-1:0]        uE_r;
  logic [SW-1:0]        sideE_r;
  logic                 rdy_E;
  logic [AZW+16:0]      az_prod;
  logic [RBW+21:0]      rb_prod;
  logic [AW-1:0]        uE_nxt;
  logic [DW-1:0]        dist_nxt;

  logic                 w_vld  [QB+1];
  logic                 w_rdy  [QB+1];
  logic [AW-1:0]        w_u    [QB+1];
  logic [SW-1:0]        w_side [QB+1];

  always_comb begin
    az_prod  = in_azimuth_bin * angle_step_r;
    rb_prod  = {in_range_bin, 1'b1} * range_step_r;
    uE_nxt   = {{(AW-ASW){angle_start_r[ASW-1]}}, angle_start_r} + AW'(az_prod) + ENTRY_OFS;
    dist_nxt = DW'({range_start_r, 1'b0}) + DW'(rb_prod);
  end

  assign rdy_E    = !vE_r || w_rdy[0];
  assign in_stall = !rdy_E;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vE_r <= 1'b0;
    end else if (rdy_E) begin
      vE_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_E) begin
      uE_r    <= uE_nxt;
      sideE_r <= {1'b0, in_echo, in_echo, dist_nxt};
    end
  end

  // ---------------------------------------------------------------- angle wrap
  assign w_vld[0]  = vE_r;
  assign w_u[0]    = uE_r;
  assign w_side[0] = sideE_r;

  for (genvar k = 0; k < QB; k++) begin : g_wrap
    p2c_wrap_cell #(
      .AW    (AW),
      .SHIFT (QB - 1 - k),
      .SW    (SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (w_vld[k]),
      .in_rdy   (w_rdy[k]),
      .in_u     (w_u[k]),
      .in_side  (w_side[k]),
      .out_vld  (w_vld[k+1]),
      .out_rdy  (w_rdy[k+1]),
      .out_u    (w_u[k+1]),
      .out_side (w_side[k+1])
    );
  end

  // ---------------------------------------------------------------- fold
  logic                 vF_r;
  logic signed [ZW-1:0] zF_r;
  logic [SW-1:0]        sideF_r;
  logic                 rdy_F;
  logic signed [19:0]   ang_raw;
  logic signed [19:0]   ang_f;
  logic                 flip_nxt;

  logic                 c_vld  [NS+1];
  logic                 c_rdy  [NS+1];
  logic signed [XW-1:0] c_x    [NS+1];
  logic signed [XW-1:0] c_y    [NS+1];
  logic signed [ZW-1:0] c_z    [NS+1];
  logic [SW-1:0]        c_side [NS+1];

  // wrapped angle in [-pi, pi], folded to [-pi/2, pi/2]; a fold negates sin and cos
  always_comb begin
    ang_raw = $signed({1'b0, w_u[QB][18:0]}) - PI_A;
    if (ang_raw > HALF_A) begin
      ang_f    = ang_raw - PI_A;
      flip_nxt = 1'b1;
    end else if (ang_raw < NHALF_A) begin
      ang_f    = ang_raw + PI_A;
      flip_nxt = 1'b1;
    end else begin
      ang_f    = ang_raw;
      flip_nxt = 1'b0;
    end
  end

  assign rdy_F      = !vF_r || c_rdy[0];
  assign w_rdy[QB]  = rdy_F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vF_r <= 1'b0;
    end else if (rdy_F) begin
      vF_r <= w_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_F) begin
      zF_r    <= {ang_f, 8'd0};
      sideF_r <= {flip_nxt, w_side[QB][SW-2:0]};
    end
  end

  // ---------------------------------------------------------------- CORDIC
  assign c_vld[0]  = vF_r;
  assign c_x[0]    = GAIN_Q30;
  assign c_y[0]    = '0;
  assign c_z[0]    = zF_r;
  assign c_side[0] = sideF_r;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    p2c_cordic_cell #(
      .IDX (i),
      .SW  (SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (c_vld[i]),
      .in_rdy   (c_rdy[i]),
      .in_x     (c_x[i]),
      .in_y     (c_y[i]),
      .in_z     (c_z[i]),
      .in_side  (c_side[i]),
      .out_vld  (c_vld[i+1]),
      .out_rdy  (c_rdy[i+1]),
      .out_x    (c_x[i+1]),
      .out_y    (c_y[i+1]),
      .out_z    (c_z[i+1]),
      .out_side (c_side[i+1])
    );
  end

  // ---------------------------------------------------------------- sign, drop to Q.24
  logic                 vP_r;
  logic signed [CW-1:0] cxP_r, syP_r;
  logic [DW-1:0]        distP_r;
  logic [LW-1:0]        levelP_r;
  logic                 rdy_P;
  logic                 rdy_M;
  logic                 rdy_S;
  logic                 rdy_O;
  logic signed [XW-1:0] xf, yf;

  always_comb begin
    if (c_side[NS][SW-1]) begin
      xf = -c_x[NS];
      yf = -c_y[NS];
    end else begin
      xf = c_x[NS];
      yf = c_y[NS];
    end
  end

  assign rdy_P     = !vP_r || rdy_M;
  assign c_rdy[NS] = rdy_P;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vP_r <= 1'b0;
    end else if (rdy_P) begin
      vP_r <= c_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_P) begin
      cxP_r    <= CW'(xf >>> 6);
      syP_r    <= CW'(yf >>> 6);
      distP_r  <= c_side[NS][DW-1:0];
      levelP_r <= c_side[NS][SW-2 -: LW];
    end
  end

  // ---------------------------------------------------------------- partial products
  logic                  vM_r;
  logic signed [LPW-1:0] pxl_r, pyl_r;
  logic signed [HPW-1:0] pxh_r, pyh_r;
  logic [LW-1:0]         levelM_r;
  logic signed [17:0]    d_lo;
  logic signed [HW:0]    d_hi;

  assign d_lo  = $signed({1'b0, distP_r[16:0]});
  assign d_hi  = $signed({1'b0, distP_r[DW-1:17]});
  assign rdy_M = !vM_r || rdy_S;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vM_r <= 1'b0;
    end else if (rdy_M) begin
      vM_r <= vP_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_M) begin
      pxl_r    <= d_lo * cxP_r;
      pyl_r    <= d_lo * syP_r;
      pxh_r    <= d_hi * cxP_r;
      pyh_r    <= d_hi * syP_r;
      levelM_r <= levelP_r;
    end
  end

  // ---------------------------------------------------------------- sum and round
  logic                 vS_r;
  logic signed [QW-1:0] qx_r, qy_r;
  logic [LW-1:0]        levelS_r;
  logic signed [PW-1:0] sx, sy;

  always_comb begin
    sx = (PW'(pxh_r) <<< 17) + PW'(pxl_r) + RND;
    sy = (PW'(pyh_r) <<< 17) + PW'(pyl_r) + RND;
  end

  assign rdy_S = !vS_r || rdy_O;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vS_r <= 1'b0;
    end else if (rdy_S) begin
      vS_r <= vM_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_S) begin
      qx_r     <= QW'(sx >>> 25);
      qy_r     <= QW'(sy >>> 25);
      levelS_r <= levelM_r;
    end
  end

  // ---------------------------------------------------------------- negate, saturate, output
  logic                 vO_r;
  logic signed [OW-1:0] pos_x_r, pos_y_r;
  logic [LW-1:0]        level_r;
  logic signed [QW:0]   nx, wy;
  logic signed [OW-1:0] pos_x_nxt, pos_y_nxt;

  always_comb begin
    nx = -$signed({qx_r[QW-1], qx_r});
    wy = $signed({qy_r[QW-1], qy_r});
    if (nx > OMAX) begin
      pos_x_nxt = OW'(OMAX);
    end else if (nx < OMIN) begin
      pos_x_nxt = OW'(OMIN);
    end else begin
      pos_x_nxt = OW'(nx);
    end
    if (wy > OMAX) begin
      pos_y_nxt = OW'(OMAX);
    end else if (wy < OMIN) begin
      pos_y_nxt = OW'(OMIN);
    end else begin
      pos_y_nxt = OW'(wy);
    end
  end

  assign rdy_O = !vO_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vO_r <= 1'b0;
    end else if (rdy_O) begin
      vO_r <= vS_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_O) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      level_r <= levelS_r;
    end
  end

  assign out_valid = vO_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_level = level_r;

  // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
  a_level_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level[15:8] == out_level[7:0])
    else $error("level is not echo*257");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    w_vld[QB] |-> w_u[QB] < AW'(TWO_PI_Q16))
    else $error("wrapped angle not below 2*pi");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    vF_r |-> (zF_r <= ZMAX) && (zF_r >= ZMIN))
    else $error("folded angle outside half pi");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vE_r && !w_rdy[0])
    else $error("input stalled with room in entry stage");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the polar to Cartesian scan converter.
`timescale 1ns / 100ps

module tb;
  import p2c_pkg::*;

  localparam int       PIPE_LAT    = 31;
  localparam int       CORDIC_ITER = 16;
  localparam longint   PI_FX       = 205887;
  localparam longint   HALF_PI_FX  = 102944;
  localparam longint   TWO_PI_FX   = 411775;
  localparam longint   GAIN_FX     = 652032874;
  localparam longint   POS_HI      = 268435455;
  localparam longint   POS_LO      = -268435456;
  localparam longint   ATAN_FX [CORDIC_ITER] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
  };

  typedef struct packed {
    logic [11:0] rb;
    logic [8:0]  az;
    logic [7:0]  echo;
  } pixel_t;

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic [LW-1:0]        lvl;
  } point_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]   cfg_paddr = '0;
  logic [PDATA_W-1:0]   cfg_pwdata = '0;
  logic [PDATA_W-1:0]   cfg_prdata;
  logic                 cfg_pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [11:0]          in_range_bin = '0;
  logic [8:0]           in_azimuth_bin = '0;
  logic [7:0]           in_echo = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [OW-1:0] out_pos_x;
  logic signed [OW-1:0] out_pos_y;
  logic [LW-1:0]        out_level;

  // shadow of the converter's registers
  logic signed [ASW-1:0] ang_start_r = -20'sd205783;
  logic [APW-1:0]        ang_step_r  = 17'd1029;
  logic [RSW-1:0]        rng_start_r = 28'd0;
  logic [RPW-1:0]        rng_step_r  = 21'd1914;

  pixel_t pix_q[$];
  point_t point_q[$];
  bit     in_taken = 1'b0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     tx_gap = 0;
  int     rx_gap = 0;
  int     hold_req = 0;
  int     hold_left = 0;
  int     bad_cnt = 0;

  polar_to_cartesian_scan_convert DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_range_bin   (in_range_bin),
    .in_azimuth_bin (in_azimuth_bin),
    .in_echo        (in_echo),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_level      (out_level)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void add_pixel(pixel_t p);
    pix_q.insert(pix_q.size(), p);
  endfunction

  function automatic void add_point(point_t p);
    point_q.insert(point_q.size(), p);
  endfunction

  function automatic point_t scan_point(logic [11:0] rb, logic [8:0] az, logic [7:0] echo);
    longint a, ang, z, cx, cy, nx, dx, dy, dist2, px, py;
    bit     flip;
    point_t p;
    a = ang_start_r;
    a = a + longint'(az) * longint'(ang_step_r);
    ang = (a + PI_FX) % TWO_PI_FX;
    if (ang < 0) ang = ang + TWO_PI_FX;
    ang = ang - PI_FX;
    // fold into the CORDIC's range, sign of both terms flips
    flip = 1'b0;
    if (ang > HALF_PI_FX) begin
      ang = ang - PI_FX;
      flip = 1'b1;
    end else if (ang < -HALF_PI_FX) begin
      ang = ang + PI_FX;
      flip = 1'b1;
    end
    z  = ang * 256;
    cx = GAIN_FX;
    cy = 0;
    for (int i = 0; i < CORDIC_ITER; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        nx = cx - dx;
        cy = cy + dy;
        z  = z - ATAN_FX[i];
      end else begin
        nx = cx + dx;
        cy = cy - dy;
        z  = z + ATAN_FX[i];
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    cx = cx >>> 6;
    cy = cy >>> 6;
    dist2 = 2 * longint'(rng_start_r) + (2 * longint'(rb) + 1) * longint'(rng_step_r);
    px = -((dist2 * cx + 64'sd16777216) >>> 25);
    py = (dist2 * cy + 64'sd16777216) >>> 25;
    if (px > POS_HI) px = POS_HI;
    if (px < POS_LO) px = POS_LO;
    if (py > POS_HI) py = POS_HI;
    if (py < POS_LO) py = POS_LO;
    p.x   = px[OW-1:0];
    p.y   = py[OW-1:0];
    p.lvl = LW'(longint'(echo) * 257);
    return p;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.rb   = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                         : 12'($urandom);
    p.az   = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 9'h1FF : 9'h000)
                                         : 9'($urandom);
    p.echo = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                         : 8'($urandom);
    return p;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= PADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ANGLE_START: ang_start_r = val[ASW-1:0];
      REG_ANGLE_STEP:  ang_step_r  = val[APW-1:0];
      REG_RANGE_START: rng_start_r = val[RSW-1:0];
      REG_RANGE_STEP:  rng_step_r  = val[RPW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] a_start, logic [31:0] a_step,
                          logic [31:0] r_start, logic [31:0] r_step);
    reg_write(REG_ANGLE_START, a_start);
    reg_write(REG_ANGLE_STEP,  a_step);
    reg_write(REG_RANGE_START, r_start);
    reg_write(REG_RANGE_STEP,  r_step);
  endtask

  // sender holds back until every item has come out again
  task automatic drain();
    while (pix_q.size() != 0 || in_valid || point_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, int tx_pct, int rx_pct, int hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n_items) add_pixel(rand_pixel());
    if (hold != 0) begin
      repeat (12) @(posedge clk);
      hold_req = hold;
    end
    drain();
  endtask

  // input driver
  always @(negedge clk) begin
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
        tx_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (pix_q.size() != 0) begin
        nxt = pix_q.pop_front();
        in_range_bin   <= nxt.rb;
        in_azimuth_bin <= nxt.az;
        in_echo        <= nxt.echo;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure, with the occasional long hold
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    point_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) add_point(scan_point(in_range_bin, in_azimuth_bin, in_echo));
    if (rst_n && out_valid && !out_stall) begin
      if (point_q.size() == 0) begin
        $error("unexpected item: pos_x %0d pos_y %0d level %0d",
               out_pos_x, out_pos_y, out_level);
        bad_cnt++;
      end else begin
        want = point_q.pop_front();
        if (out_pos_x !== want.x) begin
          $error("pos_x mismatch: expected %0d, got %0d", want.x, out_pos_x);
          bad_cnt++;
        end
        if (out_pos_y !== want.y) begin
          $error("pos_y mismatch: expected %0d, got %0d", want.y, out_pos_y);
          bad_cnt++;
        end
        if (out_level !== want.lvl) begin
          $error("level mismatch: expected %0d, got %0d", want.lvl, out_level);
          bad_cnt++;
        end
      end
    end
  end

  initial begin
    pixel_t pk;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset settings, field corners
    for (int k = 0; k < 8; k++) begin
      pk.rb   = k[0] ? 12'hFFF : 12'h000;
      pk.az   = k[1] ? 9'h1FF : 9'h000;
      pk.echo = k[2] ? 8'hFF : 8'h00;
      add_pixel(pk);
    end
    pk = '{rb: 12'd2048, az: 9'd256, echo: 8'd128};
    add_pixel(pk);
    pk = '{rb: 12'd1, az: 9'd200, echo: 8'd1};
    add_pixel(pk);
    drain();

    // quarter-turn steps: zero, +-pi/2, +-pi and wrap-around exactly
    set_regs(32'(-411775), 32'd102944, 32'd0, 32'd65536);
    for (int k = 0; k < 9; k++) begin
      pk.rb   = 12'(k * 3);
      pk.az   = 9'(k);
      pk.echo = 8'(k * 31);
      add_pixel(pk);
    end
    drain();

    set_regs(32'($urandom_range(0, 823550)) - 32'd411775, $urandom_range(0, 65536),
             $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 16));
    run_phase(180, 15, 15, 140);

    // largest register values, saturating outputs
    set_regs(32'h0007FFFF, 32'h0001FFFF, 32'h0FFFFFFF, 32'h001FFFFF);
    run_phase(180, 30, 5, 0);

    // smallest register values
    set_regs(32'h00080000, 32'h0, 32'h0, 32'h0);
    run_phase(180, 5, 30, 0);

    // whole-word random writes, only the low bits count
    set_regs($urandom, $urandom, $urandom, $urandom);
    run_phase(180, 0, 0, 0);

    set_regs(32'($urandom_range(0, 823550)) - 32'd411775, $urandom_range(0, 2048),
             $urandom_range(0, 1 << 24), $urandom_range(0, 1 << 12));
    run_phase(180, 20, 20, 90);

    // back to reset values, no idling to the end
    tx_gap = 0;
    set_regs(32'(ANGLE_START_RST), 32'(ANGLE_STEP_RST), 32'(RANGE_START_RST),
             32'(RANGE_STEP_RST));
    run_phase(180, 0, 0, 0);

    if (bad_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

[polar_to_cartesian_scan_convert.f]
src/p2c_pkg.sv
src/p2c_wrap_cell.sv
src/p2c_cordic_cell.sv
src/polar_to_cartesian_scan_convert.sv
tb/tb.sv
